>>> rtl/lwe_pkg.sv
// Shared types and constants for the LWE bit encrypt/decrypt block.
// No dependencies; compiled first.
`default_nettype none

package lwe_pkg;

  // Default scheme parameters
  localparam int MODULUS_DEF = 3329;
  localparam int DIM_DEF     = 4;

  // Field widths fixed by the request and result formats
  localparam int WORD_W     = 12;
  localparam int KEY_IDX_W  = 5;
  localparam int OP_W       = 2;
  localparam int VEC_FIELDS = 4;
  localparam int MOD_W      = 13;            // holds any modulus up to 4096

  // Datapath widths: one product, a sum of up to VEC_FIELDS products, reducer input
  localparam int PROD_W = 2 * WORD_W;
  localparam int ACC_W  = PROD_W + $clog2(VEC_FIELDS);
  localparam int X_W    = ACC_W + 1;

  // Command queue between decoder and sequencer
  localparam int CMDQ_DEPTH = 2;

  // Request op codes
  localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
  localparam logic [OP_W-1:0] OP_ENC  = 2'd1;
  localparam logic [OP_W-1:0] OP_DEC  = 2'd2;

  typedef logic [WORD_W-1:0] word_t;

  // Classified command kinds
  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_ENC,
    CMD_DEC,
    CMD_NOP
  } cmd_kind_t;

  // Decoded command; row/lane locate a key word in the row-organized key store
  typedef struct packed {
    cmd_kind_t                    kind;
    logic [KEY_IDX_W-1:0]         row;
    logic [KEY_IDX_W-1:0]         lane;
    word_t                        key_value;
    logic                         message_bit;
    word_t [VEC_FIELDS-1:0]       vec;
    word_t                        v_in;
  } cmd_t;

endpackage

`default_nettype wire

>>> rtl/lwe_if.sv
// Request and result channel interfaces (valid/ready plus payload).
// Depends on lwe_pkg.
`default_nettype none

interface lwe_req_if;
  logic                            valid;
  logic                            ready;
  logic [lwe_pkg::OP_W-1:0]        op;
  logic [lwe_pkg::KEY_IDX_W-1:0]   key_index;
  lwe_pkg::word_t                  key_value;
  logic                            message_bit;
  lwe_pkg::word_t                  vec0;
  lwe_pkg::word_t                  vec1;
  lwe_pkg::word_t                  vec2;
  lwe_pkg::word_t                  vec3;
  lwe_pkg::word_t                  v_in;

  modport source (
    output valid, op, key_index, key_value, message_bit, vec0, vec1, vec2, vec3, v_in,
    input  ready
  );
  modport sink (
    input  valid, op, key_index, key_value, message_bit, vec0, vec1, vec2, vec3, v_in,
    output ready
  );
endinterface

interface lwe_rsp_if;
  logic            valid;
  logic            ready;
  lwe_pkg::word_t  u0;
  lwe_pkg::word_t  u1;
  lwe_pkg::word_t  u2;
  lwe_pkg::word_t  u3;
  lwe_pkg::word_t  v_out;
  logic            plain_bit;

  modport source (
    output valid, u0, u1, u2, u3, v_out, plain_bit,
    input  ready
  );
  modport sink (
    input  valid, u0, u1, u2, u3, v_out, plain_bit,
    output ready
  );
endinterface

`default_nettype wire

>>> rtl/lwe_bit_encrypt_decrypt.sv
// Top level of the LWE bit encrypt/decrypt block: decoder, command queue
// and execution sequencer. Depends on lwe_pkg, lwe_if, lwe_front, lwe_cmdq, lwe_back.
//
//   channel | role   | carries
//   --------+--------+-------------------------------------------------------
//   req     | sink   | op, key_index, key_value, message_bit, vec0..vec3, v_in
//   rsp     | source | u0..u3, v_out, plain_bit (one result per request)
//
// A load or unused op is settled from idle in the sequencer. Encrypt and
// decrypt read N = min(DIM, 4) rows: the key store has one read port and
// gives one row (matrix row, public word, secret word) per cycle, followed by
// a three-stage Barrett reduction. Reset is synchronous and clears control
// only; key words are undefined until loaded. A two-entry command queue keeps
// requests flowing while a result waits on rsp.
`default_nettype none

module lwe_bit_encrypt_decrypt #(
  parameter int MODULUS = lwe_pkg::MODULUS_DEF,
  parameter int DIM     = lwe_pkg::DIM_DEF
) (
  input  logic        clk,
  input  logic        rst,
  lwe_req_if.sink     req,
  lwe_rsp_if.source   rsp
);

  logic           push;
  logic           q_full;
  logic           q_pop;
  logic           q_valid;
  lwe_pkg::cmd_t  cmd;
  lwe_pkg::cmd_t  q_head;

  // Decode requests
  lwe_front #(
    .DIM (DIM)
  ) u_front (
    .req    (req),
    .q_full (q_full),
    .push   (push),
    .cmd    (cmd)
  );

  // Decouple decode from execution
  lwe_cmdq u_cmdq (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (cmd),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (q_head)
  );

  // Execute commands
  lwe_back #(
    .MODULUS (MODULUS),
    .DIM     (DIM)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_cmd   (q_head),
    .q_pop   (q_pop),
    .rsp     (rsp)
  );

endmodule

`default_nettype wire

>>> rtl/lwe_front.sv
// Request decoder: classifies each request and maps a key index to row/lane.
// Depends on lwe_pkg and lwe_if.
`default_nettype none

module lwe_front #(
  parameter int DIM = lwe_pkg::DIM_DEF
) (
  lwe_req_if.sink          req,
  input  logic             q_full,
  output logic             push,
  output lwe_pkg::cmd_t    cmd
);

  localparam int IW        = lwe_pkg::KEY_IDX_W;
  localparam int PUB_BASE  = DIM * DIM;
  localparam int SEC_BASE  = PUB_BASE + DIM;
  localparam int KEY_WORDS = SEC_BASE + DIM;
  localparam int CMP_W     = ($clog2(KEY_WORDS + 1) > IW) ? $clog2(KEY_WORDS + 1) : IW;

  logic [CMP_W-1:0] idx;

  // Accept whenever the queue has room
  assign req.ready = !q_full;
  assign push      = req.valid && !q_full;

  // Classify and locate the key word
  always_comb begin
    idx             = CMP_W'(req.key_index);
    cmd.kind        = lwe_pkg::CMD_NOP;
    cmd.row         = '0;
    cmd.lane        = '0;
    cmd.key_value   = req.key_value;
    cmd.message_bit = req.message_bit;
    cmd.vec         = {req.vec3, req.vec2, req.vec1, req.vec0};
    cmd.v_in        = req.v_in;
    unique case (req.op)
      lwe_pkg::OP_LOAD: begin
        if (idx < CMP_W'(PUB_BASE)) begin
          // matrix word: row = idx / DIM, lane = idx % DIM
          cmd.kind = lwe_pkg::CMD_LOAD;
          cmd.lane = IW'(idx);
          for (int k = 1; k < DIM; k++) begin
            if (idx >= CMP_W'(k * DIM)) begin
              cmd.row  = IW'(k);
              cmd.lane = IW'(idx - CMP_W'(k * DIM));
            end
          end
        end else if (idx < CMP_W'(SEC_BASE)) begin
          // public vector word sits next to its matrix row
          cmd.kind = lwe_pkg::CMD_LOAD;
          cmd.row  = IW'(idx - CMP_W'(PUB_BASE));
          cmd.lane = IW'(DIM);
        end else if (idx < CMP_W'(KEY_WORDS)) begin
          // secret word follows the public word
          cmd.kind = lwe_pkg::CMD_LOAD;
          cmd.row  = IW'(idx - CMP_W'(SEC_BASE));
          cmd.lane = IW'(DIM + 1);
        end
      end
      lwe_pkg::OP_ENC: cmd.kind = lwe_pkg::CMD_ENC;
      lwe_pkg::OP_DEC: cmd.kind = lwe_pkg::CMD_DEC;
      default:         cmd.kind = lwe_pkg::CMD_NOP;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/lwe_cmdq.sv
// Small FIFO of decoded commands between decoder and sequencer.
// Depends on lwe_pkg.
`default_nettype none

module lwe_cmdq (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  lwe_pkg::cmd_t  push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output lwe_pkg::cmd_t  head
);

  localparam int DEPTH = lwe_pkg::CMDQ_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  lwe_pkg::cmd_t     slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign valid = (count != '0);
  assign full  = (count == CNT_W'(DEPTH));
  assign head  = slots[rd_ptr];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ptr_inc(wr_ptr);
      if (pop)  rd_ptr <= ptr_inc(rd_ptr);
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_cmd;
  end

endmodule

`default_nettype wire

>>> rtl/lwe_back.sv
// Execution sequencer: key store, multiply-accumulate lanes, Barrett
// reduction and the result register. Depends on lwe_pkg and lwe_if.
`default_nettype none

module lwe_back #(
  parameter int MODULUS = lwe_pkg::MODULUS_DEF,
  parameter int DIM     = lwe_pkg::DIM_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  lwe_pkg::cmd_t  q_cmd,
  output logic           q_pop,
  lwe_rsp_if.source      rsp
);

  localparam int W      = lwe_pkg::WORD_W;
  localparam int VF     = lwe_pkg::VEC_FIELDS;
  localparam int IW     = lwe_pkg::KEY_IDX_W;
  localparam int MW     = lwe_pkg::MOD_W;
  localparam int PW     = lwe_pkg::PROD_W;
  localparam int AW     = lwe_pkg::ACC_W;
  localparam int XW     = lwe_pkg::X_W;
  // rows used: vector elements past the request fields are zero
  localparam int NV     = (DIM < VF) ? DIM : VF;
  localparam int WORDS  = DIM + 2;           // A row, then P word, then S word
  localparam int P_LANE = DIM;
  localparam int S_LANE = DIM + 1;
  localparam int ROW_W  = $clog2(DIM);
  localparam int VI_W   = $clog2(VF);
  localparam int V_LANE = VF;
  localparam int LANES  = VF + 1;
  localparam int LAST   = NV + 4;
  localparam int CNT_W  = $clog2(LAST + 1);
  localparam int HALF   = MODULUS / 2;
  // multiple of the modulus above any accumulated sum, keeps decrypt non-negative
  localparam int DEC_BIAS = MODULUS * ((2 ** AW + MODULUS - 1) / MODULUS);
  localparam int BAR_M    = (2 ** XW) / MODULUS;

  localparam logic [CNT_W-1:0] C_NV    = CNT_W'(NV);
  localparam logic [CNT_W-1:0] C_ACC0  = CNT_W'(2);
  localparam logic [CNT_W-1:0] C_ACC1  = CNT_W'(NV + 1);
  localparam logic [CNT_W-1:0] C_XSTEP = CNT_W'(NV + 2);
  localparam logic [CNT_W-1:0] C_MSTEP = CNT_W'(NV + 3);
  localparam logic [CNT_W-1:0] C_LAST  = CNT_W'(LAST);
  localparam logic [MW-1:0]    Q_L     = MW'(MODULUS);
  localparam logic [MW-1:0]    HALF_L  = MW'(HALF);
  localparam logic [XW-1:0]    HALF_X  = XW'(HALF);
  localparam logic [XW-1:0]    BIAS_L  = XW'(DEC_BIAS);
  localparam logic [XW-1:0]    M_L     = XW'(BAR_M);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DONE
  } state_t;

  state_t                   state;
  logic [CNT_W-1:0]         cnt;
  logic                     out_valid;
  lwe_pkg::word_t           u_r [VF];
  lwe_pkg::word_t           v_out_r;
  logic                     plain_r;

  lwe_pkg::cmd_kind_t       kind_r;
  logic                     bit_r;
  lwe_pkg::word_t [VF-1:0]  vec_r;
  lwe_pkg::word_t           v_r;

  logic [WORDS*W-1:0]       mem [DIM];
  logic [WORDS*W-1:0]       rdata;
  logic [ROW_W-1:0]         rd_addr;
  logic [ROW_W-1:0]         wr_row;
  lwe_pkg::word_t           sel_vec;

  lwe_pkg::word_t           mul_a   [LANES];
  logic [PW-1:0]            prod    [LANES];
  logic [AW-1:0]            acc     [LANES];
  logic [XW-1:0]            xr      [LANES];
  logic [XW-1:0]            xb      [LANES];
  logic [2*XW-1:0]          bm      [LANES];
  logic [MW:0]              rr      [LANES];
  logic [MW:0]              rr_next [LANES];
  logic [MW-1:0]            red     [LANES];
  logic [XW-1:0]            xv;

  logic [MW-1:0]            d;
  logic [MW-1:0]            dist0;
  logic [MW-1:0]            distq2;
  lwe_pkg::word_t           u_fin [VF];
  lwe_pkg::word_t           v_fin;
  logic                     plain_fin;

  logic                     out_free;
  logic                     start;
  logic                     quick;
  logic                     mem_we;
  logic                     finish;

  // Handshake and dispatch decisions
  assign out_free = !out_valid || rsp.ready;
  assign start    = (state == S_IDLE) && q_valid &&
                    (q_cmd.kind == lwe_pkg::CMD_ENC || q_cmd.kind == lwe_pkg::CMD_DEC);
  assign quick    = (state == S_IDLE) && q_valid && out_free &&
                    (q_cmd.kind == lwe_pkg::CMD_LOAD || q_cmd.kind == lwe_pkg::CMD_NOP);
  assign q_pop    = start || quick;
  assign mem_we   = quick && (q_cmd.kind == lwe_pkg::CMD_LOAD);
  assign finish   = (state == S_DONE) && out_free;

  assign rd_addr  = (state == S_RUN && cnt < C_NV) ? cnt[ROW_W-1:0] : '0;
  assign wr_row   = q_cmd.row[ROW_W-1:0];

  // Key store: one word lane written per load, one row read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      for (int k = 0; k < WORDS; k++) begin
        if (q_cmd.lane == IW'(k)) mem[wr_row][k*W +: W] <= q_cmd.key_value;
      end
    end
    rdata <= mem[rd_addr];
  end

  // Multiplier operands: matrix lanes, and P (encrypt) or S (decrypt) lane
  always_comb begin
    for (int i = 0; i < LANES; i++) mul_a[i] = '0;
    for (int i = 0; i < NV; i++) mul_a[i] = rdata[i*W +: W];
    mul_a[V_LANE] = (kind_r == lwe_pkg::CMD_DEC) ? rdata[S_LANE*W +: W]
                                                 : rdata[P_LANE*W +: W];
  end

  // Scalar lane input before reduction
  always_comb begin
    if (kind_r == lwe_pkg::CMD_DEC) begin
      xv = XW'(v_r) + BIAS_L - XW'(acc[V_LANE]);
    end else begin
      xv = XW'(acc[V_LANE]) + (bit_r ? HALF_X : '0);
    end
  end

  // Barrett remainder from the estimate, then one conditional subtract
  always_comb begin
    logic [XW-1:0]    qe;
    logic [XW+MW-1:0] qm;
    logic [XW-1:0]    diff;
    for (int i = 0; i < LANES; i++) begin
      qe         = bm[i][2*XW-1:XW];
      qm         = qe * Q_L;
      diff       = xb[i] - qm[XW-1:0];
      rr_next[i] = diff[MW:0];
      red[i]     = (rr[i] >= {1'b0, Q_L}) ? MW'(rr[i] - {1'b0, Q_L}) : rr[i][MW-1:0];
    end
  end

  // Decision: strictly nearer half the modulus than zero; encrypt words passed on
  always_comb begin
    d         = red[V_LANE];
    dist0     = (d > HALF_L) ? Q_L - d : d;
    distq2    = (d >= HALF_L) ? d - HALF_L : HALF_L - d;
    plain_fin = (kind_r == lwe_pkg::CMD_DEC) && (distq2 < dist0);
    v_fin     = (kind_r == lwe_pkg::CMD_ENC) ? red[V_LANE][W-1:0] : '0;
    for (int i = 0; i < VF; i++) begin
      u_fin[i] = (kind_r == lwe_pkg::CMD_ENC && i < NV) ? red[i][W-1:0] : '0;
    end
  end

  // Datapath: row MAC, then reduction stages, stepped by cnt
  always_ff @(posedge clk) begin
    if (start) begin
      kind_r <= q_cmd.kind;
      bit_r  <= q_cmd.message_bit;
      vec_r  <= q_cmd.vec;
      v_r    <= q_cmd.v_in;
      for (int i = 0; i < LANES; i++) acc[i] <= '0;
    end
    if (state == S_RUN) begin
      if (cnt < C_NV) sel_vec <= vec_r[cnt[VI_W-1:0]];
      for (int i = 0; i < LANES; i++) prod[i] <= mul_a[i] * sel_vec;
      if (cnt >= C_ACC0 && cnt <= C_ACC1) begin
        for (int i = 0; i < LANES; i++) acc[i] <= acc[i] + AW'(prod[i]);
      end
      if (cnt == C_XSTEP) begin
        for (int i = 0; i < VF; i++) xr[i] <= XW'(acc[i]);
        xr[V_LANE] <= xv;
      end
      if (cnt == C_MSTEP) begin
        for (int i = 0; i < LANES; i++) begin
          bm[i] <= xr[i] * M_L;
          xb[i] <= xr[i];
        end
      end
      if (cnt == C_LAST) begin
        for (int i = 0; i < LANES; i++) rr[i] <= rr_next[i];
      end
    end
  end

  // Sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && rsp.ready && !quick && !finish) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (quick) begin
            // loads and unused codes give an all-zero result at once
            out_valid <= 1'b1;
            for (int i = 0; i < VF; i++) u_r[i] <= '0;
            v_out_r   <= '0;
            plain_r   <= 1'b0;
          end else if (start) begin
            state <= S_RUN;
            cnt   <= '0;
          end
        end
        S_RUN: begin
          cnt <= cnt + 1'b1;
          if (cnt == C_LAST) state <= S_DONE;
        end
        S_DONE: begin
          if (finish) begin
            out_valid <= 1'b1;
            for (int i = 0; i < VF; i++) u_r[i] <= u_fin[i];
            v_out_r   <= v_fin;
            plain_r   <= plain_fin;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.u0        = u_r[0];
  assign rsp.u1        = u_r[1];
  assign rsp.u2        = u_r[2];
  assign rsp.u3        = u_r[3];
  assign rsp.v_out     = v_out_r;
  assign rsp.plain_bit = plain_r;

endmodule

`default_nettype wire

>>> rtl/lwe_chk.sv
// Port-level checker for the LWE block, attached to the top level by bind.
// Depends on lwe_pkg and the top level lwe_bit_encrypt_decrypt.
`default_nettype none

module lwe_chk #(
  parameter int MODULUS = lwe_pkg::MODULUS_DEF
) (
  input logic            clk,
  input logic            rst,
  input logic            req_valid,
  input logic            req_ready,
  input logic            rsp_valid,
  input logic            rsp_ready,
  input lwe_pkg::word_t  rsp_u0,
  input lwe_pkg::word_t  rsp_u1,
  input lwe_pkg::word_t  rsp_u2,
  input lwe_pkg::word_t  rsp_u3,
  input lwe_pkg::word_t  rsp_v_out,
  input logic            rsp_plain_bit
);

  localparam int PEND_W = $clog2(lwe_pkg::CMDQ_DEPTH + 3);
  localparam logic [lwe_pkg::MOD_W-1:0] Q_L = lwe_pkg::MOD_W'(MODULUS);

  logic [PEND_W-1:0] pending;

  // Requests accepted but not yet answered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if ((req_valid && req_ready) && !(rsp_valid && rsp_ready)) begin
      pending <= pending + 1'b1;
    end else if (!(req_valid && req_ready) && (rsp_valid && rsp_ready)) begin
      pending <= pending - 1'b1;
    end
  end

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result dropped while stalled");

  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(rsp_u0) && $stable(rsp_u1) && $stable(rsp_u2)
      && $stable(rsp_u3) && $stable(rsp_v_out) && $stable(rsp_plain_bit))
    else $error("result changed while stalled");

  a_plain_only: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_plain_bit |-> rsp_u0 == '0 && rsp_u1 == '0 && rsp_u2 == '0
      && rsp_u3 == '0 && rsp_v_out == '0)
    else $error("decrypt result carries ciphertext words");

  a_reduced: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> {1'b0, rsp_u0} < Q_L && {1'b0, rsp_u1} < Q_L && {1'b0, rsp_u2} < Q_L
      && {1'b0, rsp_u3} < Q_L && {1'b0, rsp_v_out} < Q_L)
    else $error("result word not reduced");

  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> pending != '0)
    else $error("result without an outstanding request");

endmodule

bind lwe_bit_encrypt_decrypt lwe_chk #(
  .MODULUS (MODULUS)
) u_lwe_chk (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .rsp_u0        (rsp.u0),
  .rsp_u1        (rsp.u1),
  .rsp_u2        (rsp.u2),
  .rsp_u3        (rsp.u3),
  .rsp_v_out     (rsp.v_out),
  .rsp_plain_bit (rsp.plain_bit)
);

`default_nettype wire

>>> dv/lwe_checker.sv
`timescale 1ns / 100ps
// Scoreboard for lwe_bit_encrypt_decrypt: keeps its own copy of the key store,
// works out the response to every accepted request and compares the responses.
// Depends on lwe_pkg and the channel interfaces in lwe_if.
module lwe_checker #(
  parameter int MODULUS = lwe_pkg::MODULUS_DEF
) (
  input  logic clk,
  input  logic rst,
  lwe_req_if   req,
  lwe_rsp_if   rsp,
  output int   fail_count,
  output int   owed_count
);

  typedef lwe_pkg::word_t word_t;

  localparam int VF        = lwe_pkg::VEC_FIELDS;
  localparam int DIM       = lwe_pkg::DIM_DEF;
  localparam int KEY_WORDS = DIM * DIM + 2 * DIM;
  localparam int PUB_BASE  = DIM * DIM;
  localparam int SEC_BASE  = DIM * DIM + DIM;
  localparam logic [63:0] Q      = 64'(MODULUS);
  localparam logic [63:0] HALF_Q = 64'(MODULUS / 2);

  typedef struct packed {
    word_t [VF-1:0] u;
    word_t          v;
    logic           pbit;
  } lwe_result_t;

  word_t       key_words [KEY_WORDS];
  lwe_result_t results_owed [$];
  int          mismatches = 0;

  initial begin
    fail_count = 0;
    owed_count = 0;
  end

  // U = A^T * R, V = P . R + bit * floor(Q/2); only the final sums are reduced
  function automatic lwe_result_t predict_enc(word_t [VF-1:0] r, logic m);
    lwe_result_t res;
    logic [63:0] acc;
    res = '0;
    for (int i = 0; i < DIM; i++) begin
      acc = '0;
      for (int j = 0; j < DIM; j++)
        acc += 64'(key_words[j * DIM + i]) * 64'(r[j]);
      res.u[i] = word_t'(acc % Q);
    end
    acc = m ? HALF_Q : '0;
    for (int j = 0; j < DIM; j++)
      acc += 64'(key_words[PUB_BASE + j]) * 64'(r[j]);
    res.v = word_t'(acc % Q);
    return res;
  endfunction

  // 1 when V - S.U lands strictly nearer Q/2 than 0 (circular distance to 0)
  function automatic logic predict_dec(word_t [VF-1:0] u, word_t v);
    logic [63:0] su, vv, d, dist0, dist_half;
    su = '0;
    for (int j = 0; j < DIM; j++)
      su += 64'(key_words[SEC_BASE + j]) * 64'(u[j]);
    su = su % Q;
    vv = 64'(v) % Q;
    d = (vv + Q - su) % Q;
    dist0 = (d > HALF_Q) ? Q - d : d;
    dist_half = (d >= HALF_Q) ? d - HALF_Q : HALF_Q - d;
    return dist_half < dist0;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    mismatches++;
    $display("[%0t] mismatch on %s: got %0d, want %0d", $time, what, got, want);
  endtask

  always @(posedge clk) begin
    lwe_result_t got;
    lwe_result_t want;
    if (rst) begin
      results_owed.delete();
    end else begin
      // responses first: a request taken at this edge cannot be answered yet
      if (rsp.valid && rsp.ready) begin
        got = {rsp.u3, rsp.u2, rsp.u1, rsp.u0, rsp.v_out, rsp.plain_bit};
        if (results_owed.size() == 0) begin
          report_mismatch("response with no request owed, v_out", got.v, 0);
        end else begin
          want = results_owed.pop_front();
          for (int i = 0; i < VF; i++)
            if (got.u[i] !== want.u[i])
              report_mismatch($sformatf("u%0d", i), got.u[i], want.u[i]);
          if (got.v !== want.v)
            report_mismatch("v_out", got.v, want.v);
          if (got.pbit !== want.pbit)
            report_mismatch("plain_bit", got.pbit, want.pbit);
        end
      end

      // mirror the request into the key copy and owe its response
      if (req.valid && req.ready) begin
        want = '0;
        case (req.op)
          lwe_pkg::OP_LOAD:
            if (req.key_index < KEY_WORDS) key_words[req.key_index] = req.key_value;
          lwe_pkg::OP_ENC:
            want = predict_enc({req.vec3, req.vec2, req.vec1, req.vec0}, req.message_bit);
          lwe_pkg::OP_DEC:
            want.pbit = predict_dec({req.vec3, req.vec2, req.vec1, req.vec0}, req.v_in);
          default: ;
        endcase
        results_owed.push_back(want);
      end
    end
    fail_count <= mismatches;
    owed_count <= results_owed.size();
  end

endmodule

>>> dv/tb_lwe_bit_encrypt_decrypt.sv
`timescale 1ns / 100ps
// Top of the lwe_bit_encrypt_decrypt testbench: clock, reset, request stimulus,
// response back-pressure and the verdict. Depends on lwe_pkg, lwe_if, lwe_checker.
module tb_lwe_bit_encrypt_decrypt;

  typedef lwe_pkg::word_t word_t;

  localparam int OP_W        = lwe_pkg::OP_W;
  localparam int IDX_W       = lwe_pkg::KEY_IDX_W;
  localparam int VF          = lwe_pkg::VEC_FIELDS;
  localparam int MODULUS     = lwe_pkg::MODULUS_DEF;
  localparam int DIM         = lwe_pkg::DIM_DEF;
  localparam int KEY_WORDS   = DIM * DIM + 2 * DIM;
  localparam int HALF_Q      = MODULUS / 2;
  localparam int BOUND_LO    = HALF_Q / 2;            // last d that still decodes 0
  localparam int BOUND_HI    = HALF_Q + HALF_Q / 2;   // last d that still decodes 1
  localparam int RANDOM_REQS = 1150;
  localparam int CALM_TAIL   = 150;
  localparam int SEGMENT     = 250;
  localparam int CYCLE_LIMIT = 500000;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   owed_count;
  int   cycles = 0;
  int   send_gap_odds = 0;     // 0 disables sender gaps, else 1-in-N chance
  int   sink_stall_odds = 0;   // same for response stalls
  int   sink_hold = 0;

  lwe_req_if req ();
  lwe_rsp_if rsp ();

  lwe_bit_encrypt_decrypt #(
    .MODULUS (MODULUS),
    .DIM     (DIM)
  ) uut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  lwe_checker #(
    .MODULUS (MODULUS)
  ) u_checker (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .rsp        (rsp),
    .fail_count (fail_count),
    .owed_count (owed_count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d responses outstanding", cycles, owed_count);
      $display("Verification failed");
      $finish;
    end
  end

  // random response back-pressure in bursts
  always @(posedge clk) begin
    if (sink_hold > 0) begin
      sink_hold--;
    end else if (sink_stall_odds != 0 && $urandom_range(1, sink_stall_odds) == 1) begin
      sink_hold = $urandom_range(1, 16);
    end
    rsp.ready <= (sink_hold == 0);
  end

  // word with the extremes and the not-reduced range weighted up
  function automatic word_t pick_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return word_t'(MODULUS - 1);
      3:       return word_t'($urandom_range(MODULUS, 4095));
      default: return word_t'($urandom_range(0, MODULUS - 1));
    endcase
  endfunction

  // present one request, with an optional gap first, and hold it until taken
  task automatic send_req(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx, word_t kv,
                          logic mbit, word_t [VF-1:0] vec, word_t vin);
    if (send_gap_odds != 0 && $urandom_range(1, send_gap_odds) == 1) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    req.valid       <= 1'b1;
    req.op          <= op;
    req.key_index   <= idx;
    req.key_value   <= kv;
    req.message_bit <= mbit;
    req.vec0        <= vec[0];
    req.vec1        <= vec[1];
    req.vec2        <= vec[2];
    req.vec3        <= vec[3];
    req.v_in        <= vin;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
  endtask

  // stop sending until every owed response has come back
  task automatic drain();
    req.valid <= 1'b0;
    @(posedge clk);
    while (owed_count != 0) @(posedge clk);
  endtask

  task automatic load_full_key();
    for (int k = 0; k < KEY_WORDS; k++)
      send_req(lwe_pkg::OP_LOAD, IDX_W'(k), pick_word(), 1'($urandom_range(0, 1)),
               {pick_word(), pick_word(), pick_word(), pick_word()}, pick_word());
  endtask

  // one random request; every field is randomized, used or not, but for the decrypt edge cases
  task automatic send_random();
    int                  kind;
    logic [OP_W-1:0]     op;
    logic [IDX_W-1:0]    idx;
    word_t [VF-1:0]      vec;
    word_t               vin;
    kind = $urandom_range(0, 99);
    for (int j = 0; j < VF; j++)
      vec[j] = pick_word();
    vin = pick_word();
    if ($urandom_range(0, 7) == 0)
      idx = IDX_W'($urandom_range(KEY_WORDS, 31));
    else
      idx = IDX_W'($urandom_range(0, KEY_WORDS - 1));
    if (kind < 12) begin
      op = lwe_pkg::OP_LOAD;
    end else if (kind < 55) begin
      op = lwe_pkg::OP_ENC;
    end else if (kind < 97) begin
      op = lwe_pkg::OP_DEC;
      // zero U puts d = V mod Q right on the decision edges
      if ($urandom_range(0, 7) == 0) begin
        vec = '0;
        case ($urandom_range(0, 4))
          0:       vin = word_t'(BOUND_LO);
          1:       vin = word_t'(BOUND_LO + 1);
          2:       vin = word_t'(BOUND_HI);
          3:       vin = word_t'(BOUND_HI + 1);
          default: vin = word_t'(HALF_Q);
        endcase
      end
    end else begin
      op = OP_UNUSED;
    end
    send_req(op, idx, pick_word(), 1'($urandom_range(0, 1)), vec, vin);
  endtask

  initial begin
    word_t kv;
    req.valid       = 1'b0;
    req.op          = lwe_pkg::OP_LOAD;
    req.key_index   = '0;
    req.key_value   = '0;
    req.message_bit = 1'b0;
    req.vec0        = '0;
    req.vec1        = '0;
    req.vec2        = '0;
    req.vec3        = '0;
    req.v_in        = '0;
    rsp.ready       = 1'b0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    sink_stall_odds <= 6;

    // directed: whole key with extremes, then edge cases of every op
    for (int k = 0; k < KEY_WORDS; k++) begin
      case (k % 4)
        0:       kv = '1;
        1:       kv = '0;
        2:       kv = word_t'(MODULUS - 1);
        default: kv = pick_word();
      endcase
      send_req(lwe_pkg::OP_LOAD, IDX_W'(k), kv, 1'b0, '0, '0);
    end
    send_req(lwe_pkg::OP_LOAD, IDX_W'(KEY_WORDS), '1, 1'b1, '1, '1);   // past the store
    send_req(lwe_pkg::OP_LOAD, '1, '1, 1'b1, '1, '1);
    send_req(lwe_pkg::OP_ENC, '0, '0, 1'b0, '0, '0);
    send_req(lwe_pkg::OP_ENC, '1, '1, 1'b1, '1, '1);
    send_req(lwe_pkg::OP_DEC, '0, '0, 1'b1, '1, '1);
    send_req(lwe_pkg::OP_DEC, '0, '0, 1'b0, '0, word_t'(BOUND_LO));
    send_req(lwe_pkg::OP_DEC, '0, '0, 1'b0, '0, word_t'(BOUND_LO + 1));
    send_req(lwe_pkg::OP_DEC, '0, '0, 1'b0, '0, word_t'(BOUND_HI));
    send_req(lwe_pkg::OP_DEC, '0, '0, 1'b0, '0, word_t'(BOUND_HI + 1));
    send_req(OP_UNUSED, '1, '1, 1'b1, '1, '1);
    drain();

    // random traffic in segments of differing idle pressure, calm at the end
    for (int i = 0; i < RANDOM_REQS; i++) begin
      if (i >= RANDOM_REQS - CALM_TAIL) begin
        send_gap_odds = 0;
        sink_stall_odds <= 0;
      end else if (i % SEGMENT == 0) begin
        case ((i / SEGMENT) % 4)
          0: begin send_gap_odds = 6;  sink_stall_odds <= 6; end
          1: begin send_gap_odds = 0;  sink_stall_odds <= 0; end
          2: begin send_gap_odds = 2;  sink_stall_odds <= 2; end
          default: begin send_gap_odds = 12; sink_stall_odds <= 3; end
        endcase
      end
      if (i == RANDOM_REQS / 2)
        drain();
      if (i % 400 == 200)
        load_full_key();
      send_random();
    end

    drain();
    repeat (30) @(posedge clk);
    if (fail_count == 0 && owed_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

>>> files.f
rtl/lwe_pkg.sv
rtl/lwe_if.sv
rtl/lwe_front.sv
rtl/lwe_cmdq.sv
rtl/lwe_back.sv
rtl/lwe_bit_encrypt_decrypt.sv
rtl/lwe_chk.sv
dv/lwe_checker.sv
dv/tb_lwe_bit_encrypt_decrypt.sv
